/* rtl/core/crce2d_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crce2d_pkg: shared types and constants of the Catmull-Rom curve evaluator
// Fixed widths of the Q16.16 datapath, the register map of the setup port
// and the control point bundle handed to each coordinate pipeline.
// ----------------------------------------------------------------------------
package crce2d_pkg;

    // Fraction bits of the curve parameter s
    localparam int FRAC_BITS = 16;

    // Port and datapath widths
    localparam int W_S     = 17;                 // param_s, unsigned
    localparam int W_COORD = 32;                 // Q16.16 coordinate
    localparam int W_IDX   = 3;                  // register index
    localparam int W_COEF  = W_COORD + 4;        // Horner coefficients, signed
    localparam int W_V     = W_COORD + 5;        // Horner accumulator, signed
    localparam int W_P     = W_V + W_S + 1;      // accumulator times s
    localparam int W_R     = W_P - FRAC_BITS;    // product after rounding shift

    // Pipeline depth from accepted input to output register
    localparam int PIPE_DEPTH = 8;

    // s = 1.0
    localparam logic [W_S-1:0] S_ONE = W_S'(1 << FRAC_BITS);

    // Register map of the setup port
    typedef enum logic [W_IDX-1:0] {
        CFG_P0_X = 3'd0,
        CFG_P0_Y = 3'd1,
        CFG_P1_X = 3'd2,
        CFG_P1_Y = 3'd3,
        CFG_P2_X = 3'd4,
        CFG_P2_Y = 3'd5,
        CFG_P3_X = 3'd6,
        CFG_P3_Y = 3'd7
    } t_cfg_idx;

    // One coordinate of the four control points
    typedef struct packed {
        logic signed [W_COORD-1:0] a0;
        logic signed [W_COORD-1:0] a1;
        logic signed [W_COORD-1:0] a2;
        logic signed [W_COORD-1:0] a3;
    } t_pts;

endpackage
`default_nettype wire

/* rtl/core/catmull_rom_curve_eval_2d_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// catmull_rom_curve_eval_2d_core: 2D uniform Catmull-Rom segment evaluator
// Returns the curve point for a parameter s in Q1.16 from four control
// points held in setup registers; coordinates are signed Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Setup: write the eight control point coordinates through i_cfg_we,
//   i_cfg_idx and i_cfg_data (index 0..7: p0_x, p0_y, ... p3_y) while no
//   item is in flight. A write takes effect for items accepted on the next
//   cycle onward.
//   Input: one transfer of i_param_s on i_valid/o_ready. Values above 1.0
//   are clamped to 1.0.
//   Output: one transfer of o_curve_x/o_curve_y on o_valid/i_ready per input.
//   The path from input transfer to o_valid runs through the input register,
//   three multiply and three round-and-add stages and the saturating output
//   register; the pipeline takes one item every cycle unless it is frozen.
//   When the receiver holds i_ready low with a result waiting, the whole
//   pipeline freezes and o_ready drops; no item is lost or repeated.
//   Reset clears the control points to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module catmull_rom_curve_eval_2d_core (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    // setup port
    input  wire                                     i_cfg_we,
    input  wire          [crce2d_pkg::W_IDX-1:0]    i_cfg_idx,
    input  wire          [crce2d_pkg::W_COORD-1:0]  i_cfg_data,
    // input channel
    input  wire                                     i_valid,
    output logic                                    o_ready,
    input  wire          [crce2d_pkg::W_S-1:0]      i_param_s,
    // output channel
    output logic                                    o_valid,
    input  wire                                     i_ready,
    output logic signed  [crce2d_pkg::W_COORD-1:0]  o_curve_x,
    output logic signed  [crce2d_pkg::W_COORD-1:0]  o_curve_y
);

    localparam int DEPTH = crce2d_pkg::PIPE_DEPTH;

    logic signed [crce2d_pkg::W_COORD-1:0] r_p0_x, r_p0_y, r_p1_x, r_p1_y;
    logic signed [crce2d_pkg::W_COORD-1:0] r_p2_x, r_p2_y, r_p3_x, r_p3_y;
    logic        [DEPTH-1:0]               r_vld;
    logic                                  pipe_en;
    logic        [crce2d_pkg::W_S-1:0]     s_clamp;
    crce2d_pkg::t_pts                      pts_x, pts_y;

    // Hold setup registers, load on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_x <= '0;
            r_p0_y <= '0;
            r_p1_x <= '0;
            r_p1_y <= '0;
            r_p2_x <= '0;
            r_p2_y <= '0;
            r_p3_x <= '0;
            r_p3_y <= '0;
        end else if (i_cfg_we) begin
            case (crce2d_pkg::t_cfg_idx'(i_cfg_idx))
                crce2d_pkg::CFG_P0_X: r_p0_x <= i_cfg_data;
                crce2d_pkg::CFG_P0_Y: r_p0_y <= i_cfg_data;
                crce2d_pkg::CFG_P1_X: r_p1_x <= i_cfg_data;
                crce2d_pkg::CFG_P1_Y: r_p1_y <= i_cfg_data;
                crce2d_pkg::CFG_P2_X: r_p2_x <= i_cfg_data;
                crce2d_pkg::CFG_P2_Y: r_p2_y <= i_cfg_data;
                crce2d_pkg::CFG_P3_X: r_p3_x <= i_cfg_data;
                crce2d_pkg::CFG_P3_Y: r_p3_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign pts_x = '{a0: r_p0_x, a1: r_p1_x, a2: r_p2_x, a3: r_p3_x};
    assign pts_y = '{a0: r_p0_y, a1: r_p1_y, a2: r_p2_y, a3: r_p3_y};

    // Advance unless a finished result is stuck at the output
    assign pipe_en = !r_vld[DEPTH-1] || i_ready;
    assign o_ready = pipe_en;
    assign o_valid = r_vld[DEPTH-1];

    // Clamp s to 1.0
    assign s_clamp = (i_param_s > crce2d_pkg::S_ONE) ? crce2d_pkg::S_ONE : i_param_s;

    // Carry valid bits along with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (pipe_en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_valid};
        end
    end

    crce2d_axis u_axis_x (
        .i_clk   (i_clk),
        .i_en    (pipe_en),
        .i_s     (s_clamp),
        .i_pts   (pts_x),
        .o_coord (o_curve_x)
    );

    crce2d_axis u_axis_y (
        .i_clk   (i_clk),
        .i_en    (pipe_en),
        .i_s     (s_clamp),
        .i_pts   (pts_y),
        .o_coord (o_curve_y)
    );

endmodule
`default_nettype wire

/* rtl/core/crce2d_axis.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crce2d_axis: one coordinate of the curve evaluator
// Eight-stage Horner pipeline: an input register, three multiply stages, each
// followed by a round-and-add stage, then halving with saturation into the result register.
// ----------------------------------------------------------------------------
module crce2d_axis (
    input  wire                                     i_clk,
    input  wire                                     i_en,
    input  wire          [crce2d_pkg::W_S-1:0]      i_s,
    input  wire          crce2d_pkg::t_pts          i_pts,
    output logic signed  [crce2d_pkg::W_COORD-1:0]  o_coord
);

    localparam int WC = crce2d_pkg::W_COEF;
    localparam int WV = crce2d_pkg::W_V;
    localparam int WP = crce2d_pkg::W_P;
    localparam int WR = crce2d_pkg::W_R;
    localparam int WS = crce2d_pkg::W_S;
    localparam int WO = crce2d_pkg::W_COORD;
    localparam int FB = crce2d_pkg::FRAC_BITS;

    localparam logic signed [WP-1:0] RND_HALF = WP'(1 << (FB - 1));
    localparam logic signed [WO-1:0] SAT_MAX  = {1'b0, {(WO-1){1'b1}}};
    localparam logic signed [WO-1:0] SAT_MIN  = {1'b1, {(WO-1){1'b0}}};

    // Coefficient registers, follow the setup registers
    logic signed [WC-1:0] e0, e1, e2, e3;
    logic signed [WC-1:0] n_c0, n_c1, n_c2, n_c3;
    logic signed [WC-1:0] r_c0, r_c1, r_c2, r_c3;

    // Pipeline registers
    logic        [WS-1:0] r_s0, r_s1, r_s2, r_s3, r_s4;
    logic signed [WP-1:0] r_m1, r_m2, r_m3;
    logic signed [WV-1:0] r_v1, r_v2, r_v3;
    logic signed [WO-1:0] r_out;

    logic signed [WP-1:0] n_m1, n_m2, n_m3;
    logic signed [WP-1:0] t_m1, t_m2, t_m3;
    logic signed [WR-1:0] q_m1, q_m2, q_m3;
    logic signed [WV-1:0] n_v1, n_v2, n_v3;
    logic signed [WV:0]   t_half;
    logic signed [WV-1:0] q_half;
    logic signed [WO-1:0] n_out;

    // Form Horner coefficients from the control points
    always_comb begin
        e0   = WC'(i_pts.a0);
        e1   = WC'(i_pts.a1);
        e2   = WC'(i_pts.a2);
        e3   = WC'(i_pts.a3);
        n_c0 = e1 + e1;
        n_c1 = e2 - e0;
        n_c2 = (e0 + e0) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
        n_c3 = e3 - e0 + ((e1 <<< 1) + e1) - ((e2 <<< 1) + e2);
    end

    always_ff @(posedge i_clk) begin
        r_c0 <= n_c0;
        r_c1 <= n_c1;
        r_c2 <= n_c2;
        r_c3 <= n_c3;
    end

    // Multiply stages
    assign n_m1 = WP'(r_c3) * $signed({1'b0, r_s0});
    assign n_m2 = r_v1 * $signed({1'b0, r_s2});
    assign n_m3 = r_v2 * $signed({1'b0, r_s4});

    // Round to nearest (ties up), drop the fraction bits, add next coefficient
    always_comb begin
        t_m1 = r_m1 + RND_HALF;
        t_m2 = r_m2 + RND_HALF;
        t_m3 = r_m3 + RND_HALF;
        q_m1 = $signed(t_m1[WP-1:FB]);
        q_m2 = $signed(t_m2[WP-1:FB]);
        q_m3 = $signed(t_m3[WP-1:FB]);
        n_v1 = $signed(q_m1[WV-1:0]) + WV'(r_c2);
        n_v2 = $signed(q_m2[WV-1:0]) + WV'(r_c1);
        n_v3 = $signed(q_m3[WV-1:0]) + WV'(r_c0);
    end

    // Halve with rounding, then saturate to the coordinate range
    always_comb begin
        t_half = (WV+1)'(r_v3) + (WV+1)'(1);
        q_half = $signed(t_half[WV:1]);
        if (q_half > WV'(SAT_MAX)) begin
            n_out = SAT_MAX;
        end else if (q_half < WV'(SAT_MIN)) begin
            n_out = SAT_MIN;
        end else begin
            n_out = $signed(q_half[WO-1:0]);
        end
    end

    // Advance all stages together
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s0  <= i_s;
            r_m1  <= n_m1;
            r_s1  <= r_s0;
            r_v1  <= n_v1;
            r_s2  <= r_s1;
            r_m2  <= n_m2;
            r_s3  <= r_s2;
            r_v2  <= n_v2;
            r_s4  <= r_s3;
            r_m3  <= n_m3;
            r_v3  <= n_v3;
            r_out <= n_out;
        end
    end

    assign o_coord = r_out;

endmodule
`default_nettype wire
